FILE: rtl/clst_pkg.sv
// ----------------------------------------------------------------------------
// clst_pkg
// Shared types and constants for the cursor list store.
// ----------------------------------------------------------------------------
package clst_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_DELETE  = 3'd1,
    OP_READ    = 3'd2,
    OP_START   = 3'd3,
    OP_END     = 3'd4,
    OP_ADVANCE = 3'd5,
    OP_RETREAT = 3'd6,
    OP_CLEAR   = 3'd7
  } op_e;

  // Broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic                  shift_up;
    logic                  shift_dn;
    logic [CNT_W-1:0]      cursor;
    logic [DATA_WIDTH-1:0] wdata;
  } cell_ctrl_t;

endpackage

FILE: rtl/cursor_list_store_core.sv
// ----------------------------------------------------------------------------
// cursor_list_store_core
// Ordered list of fixed capacity with a cursor, built as a row of cells.
// ----------------------------------------------------------------------------
// Usage: each input item carries an operation code on mode_i and, for an
// insert, a value on data_in_i. An item is taken at a rising edge where
// in_valid_i is high and in_stall_o is low. Every item yields exactly one
// result item on the output channel: status, read data, count, cursor and
// the four flags. A result is taken where out_valid_o is high and
// out_stall_i is low.
// out_valid_o rises in the cycle after acceptance, and the block takes one
// item per cycle while the receiver does not stall. The row of cells moves
// every entry in parallel on an insert or a delete, so no operation is slower.
// The result sits in an output register. While the receiver stalls, that
// register holds and in_stall_o is raised; as soon as the result is taken
// a new item is accepted in the same cycle.
// Reset clears the count, the cursor and the output valid. Stored entries
// are not cleared; only positions below the count are ever read.
// ----------------------------------------------------------------------------
module cursor_list_store_core
  import clst_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            mode_i,
  input  logic [DATA_WIDTH-1:0] data_in_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  ok_o,
  output logic [DATA_WIDTH-1:0] data_out_o,
  output logic [CNT_W-1:0]      count_o,
  output logic [CNT_W-1:0]      cursor_o,
  output logic                  is_empty_o,
  output logic                  is_full_o,
  output logic                  at_start_o,
  output logic                  at_end_o
);

  localparam logic [CNT_W-1:0] CapCount = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] One      = CNT_W'(1);

  logic [CNT_W-1:0]      cnt_q, cnt_d, cur_q, cur_d;
  logic                  out_valid_q;
  logic                  ok_q, ok_d;
  logic [DATA_WIDTH-1:0] rdata_q, rdata_d;
  logic                  accept;
  op_e                   op;
  cell_ctrl_t            ctrl;

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_hit  [CAPACITY];
  logic [DATA_WIDTH-1:0] hit_data;

  // A new item may enter whenever the output register is free or drains now.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign op         = op_e'(mode_i);

  // The entry under the cursor, collected from the row.
  always_comb begin
    hit_data = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      hit_data = hit_data | cell_hit[k];
    end
  end

  always_comb begin
    cnt_d         = cnt_q;
    cur_d         = cur_q;
    ok_d          = 1'b0;
    rdata_d       = '0;
    ctrl.shift_up = 1'b0;
    ctrl.shift_dn = 1'b0;
    ctrl.cursor   = cur_q;
    ctrl.wdata    = data_in_i;
    case (op)
      OP_INSERT: begin
        // The cursor never passes the count, so only a full list refuses.
        if (cnt_q < CapCount) begin
          ctrl.shift_up = accept;
          cnt_d         = cnt_q + One;
          ok_d          = 1'b1;
        end
      end
      OP_DELETE: begin
        // Refused when the cursor is at the end, which covers an empty list.
        if (cur_q < cnt_q) begin
          ctrl.shift_dn = accept;
          cnt_d         = cnt_q - One;
          ok_d          = 1'b1;
        end
      end
      OP_READ: begin
        if (cur_q < cnt_q) begin
          rdata_d = hit_data;
          ok_d    = 1'b1;
        end
      end
      OP_START: begin
        cur_d = '0;
        ok_d  = 1'b1;
      end
      OP_END: begin
        cur_d = cnt_q;
        ok_d  = 1'b1;
      end
      OP_ADVANCE: begin
        if (cur_q < cnt_q) begin
          cur_d = cur_q + One;
          ok_d  = 1'b1;
        end
      end
      OP_RETREAT: begin
        if (cur_q != '0) begin
          cur_d = cur_q - One;
          ok_d  = 1'b1;
        end
      end
      OP_CLEAR: begin
        cnt_d = '0;
        cur_d = '0;
        ok_d  = 1'b1;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  // Row of cells; the ends are tied off since those neighbors are never used.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_data, next_data;
    if (g == 0) begin : g_first
      assign prev_data = '0;
    end else begin : g_mid_lo
      assign prev_data = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_data = cell_data[g];
    end else begin : g_mid_hi
      assign next_data = cell_data[g+1];
    end
    clst_cell u_cell (
      .clk_i       (clk_i),
      .cell_idx_i  (CNT_W'(g)),
      .ctrl_i      (ctrl),
      .prev_data_i (prev_data),
      .next_data_i (next_data),
      .data_o      (cell_data[g]),
      .hit_data_o  (cell_hit[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q <= cnt_d;
        cur_q <= cur_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload; count and cursor outputs come straight from the state.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q    <= ok_d;
      rdata_q <= rdata_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign data_out_o  = rdata_q;
  assign count_o     = cnt_q;
  assign cursor_o    = cur_q;
  assign is_empty_o  = (cnt_q == '0);
  assign is_full_o   = (cnt_q == CapCount);
  assign at_start_o  = (cur_q == '0);
  assign at_end_o    = (cur_q == cnt_q);

endmodule

FILE: rtl/clst_cell.sv
// ----------------------------------------------------------------------------
// clst_cell
// One list entry. Takes data from its neighbors when the list shifts.
// ----------------------------------------------------------------------------
module clst_cell
  import clst_pkg::*;
(
  input  logic                  clk_i,
  input  logic [CNT_W-1:0]      cell_idx_i,
  input  cell_ctrl_t            ctrl_i,
  input  logic [DATA_WIDTH-1:0] prev_data_i,
  input  logic [DATA_WIDTH-1:0] next_data_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [DATA_WIDTH-1:0] hit_data_o
);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  at_cur, above_cur;

  assign at_cur    = (cell_idx_i == ctrl_i.cursor);
  assign above_cur = (cell_idx_i > ctrl_i.cursor);

  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift_up) begin
      if (at_cur) begin
        data_d = ctrl_i.wdata;
      end else if (above_cur) begin
        data_d = prev_data_i;
      end
    end else if (ctrl_i.shift_dn) begin
      if (at_cur || above_cur) begin
        data_d = next_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o     = data_q;
  // The cell under the cursor drives its entry; the others drive zero.
  assign hit_data_o = at_cur ? data_q : '0;

endmodule

FILE: rtl/clst_checker.sv
// ----------------------------------------------------------------------------
// clst_checker
// Port-level checks for the cursor list store, bound to the top level.
// ----------------------------------------------------------------------------
module clst_checker
  import clst_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic [2:0]            mode_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic                  ok_o,
  input logic [DATA_WIDTH-1:0] data_out_o,
  input logic [CNT_W-1:0]      count_o,
  input logic [CNT_W-1:0]      cursor_o,
  input logic                  is_full_o
);

  // Each accepted item shows its result in the next cycle.
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("result missing after accepted item");

  // The cursor never passes the count, and the count never passes capacity.
  a_bounds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cursor_o <= count_o) && (count_o <= CNT_W'(CAPACITY)))
    else $error("cursor or count out of bounds");

  // Read data is zero unless an operation succeeded.
  a_data_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (data_out_o != '0) |-> ok_o)
    else $error("data on a refused operation");

  // A successful insert grows the count by one.
  a_insert : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (mode_i == OP_INSERT) && !is_full_o && out_valid_o
    |=> ok_o && (count_o == $past(count_o) + CNT_W'(1)))
    else $error("insert did not grow the list");

  // A stalled result holds.
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(count_o)
      && $stable(cursor_o) && $stable(data_out_o) && $stable(ok_o))
    else $error("stalled result changed");

endmodule

bind cursor_list_store_core clst_checker u_clst_checker (.*);

FILE: bench/cursor_list_store_core_test.sv
// ----------------------------------------------------------------------------
// cursor_list_store_core_test
// Self-checking bench for the cursor list store: random list operations
// against a behavioral list, with random idling on both channels.
// ----------------------------------------------------------------------------
module cursor_list_store_core_test;
  import clst_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One list operation waiting to be sent. The gap is the number of idle
  // cycles before it goes out. With wait_idle set, the sender also holds it
  // back until every outstanding result has come back.
  typedef struct {
    op_e                   mode;
    logic [DATA_WIDTH-1:0] data;
    int                    gap;
    bit                    wait_idle;
  } list_op_t;

  // What the list should report for one operation.
  typedef struct {
    logic                  ok;
    logic [DATA_WIDTH-1:0] rdata;
    logic [CNT_W-1:0]      count;
    logic [CNT_W-1:0]      cursor;
    logic                  empty;
    logic                  full;
    logic                  at_head;
    logic                  at_tail;
  } list_result_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [2:0]            mode_i      = OP_READ;
  logic [DATA_WIDTH-1:0] data_in_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  ok_o;
  logic [DATA_WIDTH-1:0] data_out_o;
  logic [CNT_W-1:0]      count_o;
  logic [CNT_W-1:0]      cursor_o;
  logic                  is_empty_o;
  logic                  is_full_o;
  logic                  at_start_o;
  logic                  at_end_o;

  cursor_list_store_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .data_in_i   (data_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ok_o        (ok_o),
    .data_out_o  (data_out_o),
    .count_o     (count_o),
    .cursor_o    (cursor_o),
    .is_empty_o  (is_empty_o),
    .is_full_o   (is_full_o),
    .at_start_o  (at_start_o),
    .at_end_o    (at_end_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  list_op_t     pending_ops[$];
  list_result_t expected_results[$];
  int           mismatches = 0;
  bit           tx_calm    = 1'b0;
  bit           rx_calm    = 1'b0;

  // Shadow copy of the list. Entries above the fill level are never looked
  // at, so they need no reset value.
  localparam int IdxW = $clog2(CAPACITY);
  logic [DATA_WIDTH-1:0] shadow_entries [CAPACITY];
  logic [CNT_W-1:0]      shadow_fill = '0;
  logic [CNT_W-1:0]      shadow_pos  = '0;

  // Applies one accepted operation to the shadow list and queues the result
  // the block has to return for it.
  function automatic void list_apply(op_e mode, logic [DATA_WIDTH-1:0] data);
    list_result_t res;
    res.ok    = 1'b0;
    res.rdata = '0;
    case (mode)
      OP_INSERT: begin
        // Refused when full; otherwise everything from the cursor up moves
        // one place and the new value lands under the cursor.
        if (shadow_fill < CAPACITY) begin
          for (int k = CAPACITY - 1; k > 0; k--) begin
            if (k > shadow_pos && k <= shadow_fill) shadow_entries[k] = shadow_entries[k-1];
          end
          shadow_entries[shadow_pos[IdxW-1:0]] = data;
          shadow_fill++;
          res.ok = 1'b1;
        end
      end
      OP_DELETE: begin
        // Nothing sits under a cursor that is at the end, so it is refused.
        if (shadow_pos < shadow_fill) begin
          for (int k = 0; k < CAPACITY - 1; k++) begin
            if (k >= shadow_pos && k + 1 < shadow_fill) shadow_entries[k] = shadow_entries[k+1];
          end
          shadow_fill--;
          res.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (shadow_pos < shadow_fill) begin
          res.rdata = shadow_entries[shadow_pos[IdxW-1:0]];
          res.ok    = 1'b1;
        end
      end
      OP_START: begin
        shadow_pos = '0;
        res.ok     = 1'b1;
      end
      OP_END: begin
        shadow_pos = shadow_fill;
        res.ok     = 1'b1;
      end
      OP_ADVANCE: begin
        // Steps saturate at the list bounds and report a refusal there.
        if (shadow_pos < shadow_fill) begin
          shadow_pos++;
          res.ok = 1'b1;
        end
      end
      OP_RETREAT: begin
        if (shadow_pos != 0) begin
          shadow_pos--;
          res.ok = 1'b1;
        end
      end
      default: begin
        // Clear drops the fill level and the cursor; old entries stay put
        // but are out of reach.
        shadow_fill = '0;
        shadow_pos  = '0;
        res.ok      = 1'b1;
      end
    endcase
    res.count   = shadow_fill;
    res.cursor  = shadow_pos;
    res.empty   = (shadow_fill == 0);
    res.full    = (shadow_fill == CAPACITY);
    res.at_head = (shadow_pos == 0);
    res.at_tail = (shadow_pos == shadow_fill);
    expected_results.push_back(res);
  endfunction

  task automatic report_mismatch(string what, logic [DATA_WIDTH-1:0] want,
                                 logic [DATA_WIDTH-1:0] got);
    $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    mismatches++;
  endtask

  // ------------------------------------------------------------------------
  // Sender. An operation is taken out of the pending queue, waits out its
  // gap (and, if marked, until the block has nothing outstanding), and is
  // then presented until the block accepts it. When the accepted item is
  // followed by one with no gap, in_valid_i simply stays high.
  // ------------------------------------------------------------------------
  list_op_t op_now;
  bit       op_staged  = 1'b0;
  bit       op_driven  = 1'b0;
  int       gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      op_staged  = 1'b0;
      op_driven  = 1'b0;
      gap_left   = 0;
    end else begin
      if (op_driven && in_valid_i && !in_stall_o) begin
        list_apply(op_now.mode, op_now.data);
        op_driven = 1'b0;
      end
      if (!op_driven && !op_staged && pending_ops.size() != 0) begin
        op_now    = pending_ops.pop_front();
        gap_left  = op_now.gap;
        op_staged = 1'b1;
      end
      if (op_staged) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!(op_now.wait_idle && expected_results.size() != 0)) begin
          op_staged = 1'b0;
          op_driven = 1'b1;
          mode_i    <= op_now.mode;
          data_in_i <= op_now.data;
        end
      end
      in_valid_i <= op_driven;
    end
  end

  // ------------------------------------------------------------------------
  // Receiver. Each taken result is compared field by field with the oldest
  // expectation, and a fresh stall length is drawn. The stall counter only
  // runs down while a result is waiting, so stalls land on live results.
  // ------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("[%0t] result with no operation outstanding", $realtime);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (ok_o !== want.ok)
            report_mismatch("ok", DATA_WIDTH'(want.ok), DATA_WIDTH'(ok_o));
          if (data_out_o !== want.rdata)
            report_mismatch("data_out", want.rdata, data_out_o);
          if (count_o !== want.count)
            report_mismatch("count", DATA_WIDTH'(want.count), DATA_WIDTH'(count_o));
          if (cursor_o !== want.cursor)
            report_mismatch("cursor", DATA_WIDTH'(want.cursor), DATA_WIDTH'(cursor_o));
          if (is_empty_o !== want.empty)
            report_mismatch("is_empty", DATA_WIDTH'(want.empty), DATA_WIDTH'(is_empty_o));
          if (is_full_o !== want.full)
            report_mismatch("is_full", DATA_WIDTH'(want.full), DATA_WIDTH'(is_full_o));
          if (at_start_o !== want.at_head)
            report_mismatch("at_start", DATA_WIDTH'(want.at_head), DATA_WIDTH'(at_start_o));
          if (at_end_o !== want.at_tail)
            report_mismatch("at_end", DATA_WIDTH'(want.at_tail), DATA_WIDTH'(at_end_o));
        end
        stall_left = rx_calm ? 0 : $urandom_range(0, 18);
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      end else if (out_valid_o && stall_left > 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  // Queues one operation; the gap comes from the current pacing of the sender.
  task automatic queue_op(op_e mode, logic [DATA_WIDTH-1:0] data, bit wait_idle = 1'b0);
    list_op_t op;
    op.mode      = mode;
    op.data      = data;
    op.gap       = tx_calm ? 0 : $urandom_range(0, 18);
    op.wait_idle = wait_idle;
    pending_ops.push_back(op);
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
  endtask

  function automatic logic [DATA_WIDTH-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Operation mix per phase: filling, balanced and draining. The columns
  // follow the operation codes from insert through clear.
  int op_weights [3][8] = '{
    '{60,  6, 10, 4, 4, 7, 7, 2},
    '{25, 20, 20, 6, 6, 10, 10, 3},
    '{10, 40, 20, 6, 6, 8, 8, 2}
  };

  function automatic op_e pick_op(int phase);
    int roll;
    roll = $urandom_range(0, 99);
    for (int k = 0; k < 8; k++) begin
      if (roll < op_weights[phase][k]) return op_e'(k);
      roll -= op_weights[phase][k];
    end
    return OP_READ;
  endfunction

  initial begin
    int phase;
    int phase_len;
    int queued;

    // Directed opening: every refusal on an empty list, the data extremes,
    // inserts at the front and at the tail, and the saturating steps.
    queue_op(OP_READ, '0);
    queue_op(OP_DELETE, '0);
    queue_op(OP_RETREAT, '0);
    queue_op(OP_ADVANCE, '0);
    queue_op(OP_END, '0);
    queue_op(OP_INSERT, '0);
    queue_op(OP_INSERT, '1);
    queue_op(OP_READ, 32'h1234_5678);
    queue_op(OP_ADVANCE, '0);
    queue_op(OP_READ, '0);
    queue_op(OP_ADVANCE, '0);
    queue_op(OP_ADVANCE, '0);
    queue_op(OP_READ, '0);
    queue_op(OP_DELETE, '0);
    queue_op(OP_INSERT, 32'hA5A5_5A5A);
    queue_op(OP_RETREAT, '0);
    queue_op(OP_DELETE, '0);
    queue_op(OP_START, '0);
    queue_op(OP_RETREAT, '0);
    queue_op(OP_DELETE, '0);
    queue_op(OP_READ, '0);
    queue_op(OP_CLEAR, '0);
    queue_op(OP_READ, '0);

    // Random phases. The first one fills the list, so the full case and
    // refused inserts come up early. Each phase opens with an item that
    // waits until the block has gone quiet.
    queued = 0;
    phase  = 0;
    while (queued < 1150) begin
      phase_len = $urandom_range(40, 120);
      queue_op(pick_op(phase), pick_value(), 1'b1);
      for (int n = 1; n < phase_len; n++) queue_op(pick_op(phase), pick_value());
      queued += phase_len;
      phase = $urandom_range(0, 2);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() != 0 || op_staged || op_driven || expected_results.size() != 0)
      @(posedge clk_i);
    // Run on past the drain so that a stray extra result would still be seen.
    repeat (8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
